@@ sv/pftb_pkg.sv @@
// ============================================================================
// pftb_pkg: shared types and constants of the per-flow token bucket
// Holds the flow table size, the fixed-point format, the register map
// and the control state encoding.
// ============================================================================
`default_nettype none

package pftb_pkg;

    // Flow table geometry; FLOWS is a power of two so the index is a bit slice.
    localparam int FLOWS  = 1024;
    localparam int FLOW_W = $clog2(FLOWS);
    localparam int ID_W   = 10;

    // Token levels and the refill rate carry FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 16;
    localparam logic [31:0] ONE_LEVEL = 32'(64'd1 << FRAC_BITS);

    // One table entry: valid flag, time of last allowed request, token level.
    localparam int ENTRY_W = 1 + 32 + 32;

    // Configuration register map (word index, byte address = 4 * index).
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_REFILL   = 2'd1;
    localparam logic [1:0] REG_EXPIRY   = 2'd2;

    localparam logic [15:0] CAPACITY_RST = 16'd10;
    localparam logic [31:0] REFILL_RST   = 32'd655;
    localparam logic [31:0] EXPIRY_RST   = 32'd60000;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC
    } t_state;

endpackage

`default_nettype wire

@@ sv/pftb_ram.sv @@
// ============================================================================
// pftb_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module pftb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/per_flow_token_bucket.sv @@
// ============================================================================
// per_flow_token_bucket: per-flow token bucket policer
// Charges one token per request against a table of per-flow buckets.
// ============================================================================
// Usage:
// Requests arrive on the s_axis channel; each carries a flow index and a
// millisecond timestamp. For every request exactly one response leaves on
// the m_axis channel with the allow/deny decision and the token level that
// remains after the decision. Rate and capacity are set through the APB
// port by the user, only while no request is in flight; the block does not enforce it.
// Flow: a request is taken in the idle state, which also issues the table
// read; the fetched entry and the refill product are registered in the
// read state, and the decision, the result register load and, for an
// allowed request, the table write-back happen in the calc state. No new
// request is taken until the current one is back in idle; the
// read-modify-write of the single flow table sets this.
// Reset: after i_rst_n is released the block sweeps the flow table once,
// one entry per cycle, clearing every valid flag; during the sweep
// s_axis_tready stays low. APB writes are taken throughout.
// Stall: the response register holds its value while m_axis_tready is low.
// A finished request then waits in the decision stage, and s_axis_tready
// stays low until the response register frees up.
// ============================================================================
`default_nettype none

module per_flow_token_bucket
    import pftb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // Request stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [9:0] flow_id, [41:10] now_ms, [47:42] zero
    input  wire logic [47:0]        s_axis_tdata,

    // Response stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [0] allowed, [32:1] tokens_left, [39:33] zero
    output logic      [39:0]        m_axis_tdata,

    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_capacity;
    logic [31:0] r_refill;
    logic [31:0] r_expiry;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
            r_refill   <= REFILL_RST;
            r_expiry   <= EXPIRY_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_CAPACITY: r_capacity <= pwdata[15:0];
                REG_REFILL:   r_refill   <= pwdata;
                REG_EXPIRY:   r_expiry   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CAPACITY: prdata = {16'd0, r_capacity};
            REG_REFILL:   prdata = r_refill;
            REG_EXPIRY:   prdata = r_expiry;
            default:      prdata = 32'd0;
        endcase
    end

    // Capacity as a fixed-point level, saturated to 32 bits when the
    // fraction width pushes it past the level register.
    logic [63:0] cap_wide;
    logic [31:0] cap_level;
    logic [31:0] fresh_level;

    assign cap_wide    = 64'(r_capacity) << FRAC_BITS;
    assign cap_level   = (|cap_wide[63:32]) ? 32'hFFFF_FFFF : cap_wide[31:0];
    assign fresh_level = (cap_level >= ONE_LEVEL) ? (cap_level - ONE_LEVEL) : 32'd0;

    // ------------------------------------------------------------------
    // Flow table: {valid, last_time, token_level}
    // ------------------------------------------------------------------
    logic               mem_we;
    logic [FLOW_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ENTRY_W-1:0] mem_rdata;

    pftb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FLOWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (FLOW_W'(s_axis_tdata[ID_W-1:0])),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [FLOW_W-1:0] r_clr_idx;
    logic [FLOW_W-1:0] r_flow;
    logic [31:0]       r_now;
    logic              r_fresh;
    logic [31:0]       r_level_old;
    logic [63:0]       r_prod;
    logic              r_out_valid;
    logic              r_out_allowed;
    logic [31:0]       r_out_tokens;

    logic in_accept;
    logic clr_last;
    logic out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign clr_last  = (r_clr_idx == FLOW_W'(FLOWS - 1));
    assign out_free  = !r_out_valid || m_axis_tready;

    // Read stage: age check and refill product from the fetched entry.
    logic        rd_valid;
    logic [31:0] rd_time;
    logic [31:0] rd_level;
    logic [31:0] elapsed;

    assign rd_valid = mem_rdata[64];
    assign rd_time  = mem_rdata[63:32];
    assign rd_level = mem_rdata[31:0];
    assign elapsed  = r_now - rd_time;

    // Decision stage: restart a new or expired flow at capacity, else refill and
    // cap at capacity; spend one token if one is there. The capped and uncapped paths are evaluated side by side.
    logic [64:0] sum;
    logic        over_cap;
    logic        calc_allowed;
    logic [31:0] calc_level;

    assign sum      = {33'd0, r_level_old} + {1'b0, r_prod};
    assign over_cap = sum > {33'd0, cap_level};

    always_comb begin
        if (r_fresh) begin
            calc_allowed = 1'b1;
            calc_level   = fresh_level;
        end else if (over_cap) begin
            calc_allowed = cap_level >= ONE_LEVEL;
            calc_level   = calc_allowed ? (cap_level - ONE_LEVEL) : cap_level;
        end else begin
            calc_allowed = sum >= {33'd0, ONE_LEVEL};
            calc_level   = calc_allowed ? (sum[31:0] - ONE_LEVEL) : sum[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Control: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (in_accept) n_state = ST_READ;
            ST_READ:  n_state = ST_CALC;
            ST_CALC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Control: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_flow;
        mem_wdata     = {1'b1, r_now, calc_level};
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_re        = s_axis_tvalid;
            end
            ST_READ: ;
            ST_CALC: begin
                mem_we = out_free && calc_allowed;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == ST_CALC && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_flow <= FLOW_W'(s_axis_tdata[ID_W-1:0]);
            r_now  <= s_axis_tdata[41:10];
        end
        if (r_state == ST_READ) begin
            r_fresh     <= !rd_valid || (elapsed >= r_expiry);
            r_level_old <= rd_level;
            r_prod      <= 64'(elapsed) * 64'(r_refill);
        end
        if (r_state == ST_CALC && out_free) begin
            r_out_allowed <= calc_allowed;
            r_out_tokens  <= calc_level;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_tokens, r_out_allowed};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Only one request is in flight: an accepted request closes the input.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request accepted while another one is in flight");

    // Outside the clearing sweep the table is only written for allowed requests.
    a_write_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_CLEAR) |-> (r_state == ST_CALC && calc_allowed))
        else $error("flow table written for a denied request");

    // A response is only launched from the decision stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_CALC))
        else $error("response appeared without a decision");

endmodule

`default_nettype wire
